[design/i2c_lcd_nibble_writer_macros.svh]
// Assertion macros for the I2C display nibble writer.
// Included by the modules that check their own logic; no other dependencies.
`ifndef I2C_LCD_NIBBLE_WRITER_MACROS_SVH
`define I2C_LCD_NIBBLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Check sampled on the rising clock edge, off while reset is high
`define I2CLN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("i2cln assertion failed");
// Check sampled on the rising clock edge, also live during reset
`define I2CLN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("i2cln assertion failed");
`else
`define I2CLN_ASSERT(label, prop)
`define I2CLN_ASSERT_ALWAYS(label, prop)
`endif

`endif

[design/i2cln_pkg.sv]
// Shared types and constants of the I2C display nibble writer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2cln_pkg;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_BACKLIGHT_ON  = 1'b1;

  localparam int CfgDataWidth = 7;

  localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd39;
  localparam logic       BACKLIGHT_ON_RESET  = 1'b1;

  // Request classes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Bus phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_BIT   = 3'd2;
  localparam logic [2:0] PH_ACK   = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  // Expander bit masks
  localparam logic [7:0] EXP_EN     = 8'h04;
  localparam logic [7:0] EXP_BL     = 8'h08;
  localparam logic [7:0] EXP_RS     = 8'h01;
  localparam logic [7:0] NIBBLE_HI  = 8'hF0;
  localparam logic [2:0] LAST_DATA_BYTE = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] lcd_byte;
    logic       register_select;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic done_res;
    logic nack_error;
    logic refused;
  } res_t;

  // Classified request held in the queue
  typedef struct packed {
    logic       op;
    logic [7:0] lcd_byte;
    logic       register_select;
    logic       sda_sample;
  } q_item_t;

  typedef struct packed {
    logic [6:0] slave_address;
    logic       backlight_on;
  } cfg_t;

endpackage

[design/i2cln_queue.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on i2cln_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_lcd_nibble_writer_macros.svh"

module i2cln_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  i2cln_pkg::req_t  req_data,
  output logic             q_valid,
  output i2cln_pkg::q_item_t q_item,
  input  logic             q_pop
);

  i2cln_pkg::q_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  i2cln_pkg::q_item_t item_in;

  // Classify the incoming request
  always_comb begin
    item_in.op              = req_data.command ? i2cln_pkg::OP_SEND : i2cln_pkg::OP_TICK;
    item_in.lcd_byte        = req_data.lcd_byte;
    item_in.register_select = req_data.register_select;
    item_in.sda_sample      = req_data.sda_sample;
  end

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign q_item    = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `I2CLN_ASSERT_ALWAYS(a_count_bound, rst || count != 2'd3)
  `I2CLN_ASSERT(a_pop_only_valid, q_pop |-> q_valid)
  `I2CLN_ASSERT(a_push_grows, (push && !q_pop) |=> count == $past(count) + 2'd1)

endmodule

[design/i2cln_engine.sv]
// Back end: bus sequencer that steps one delay phase per queued request,
// plus the output register. Depends on i2cln_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_lcd_nibble_writer_macros.svh"

module i2cln_engine (
  input  logic               clk,
  input  logic               rst,
  input  i2cln_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  i2cln_pkg::q_item_t q_item,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_stall,
  output i2cln_pkg::res_t    res_data
);

  logic [2:0] phase,       phase_next;
  logic [1:0] sub_step,    sub_step_next;
  logic [2:0] bit_count,   bit_count_next;
  logic [2:0] byte_count,  byte_count_next;
  logic [7:0] shift_byte,  shift_byte_next;
  logic [7:0] held_byte,   held_byte_next;
  logic       held_select, held_select_next;
  logic       error_seen,  error_seen_next;
  logic       scl_level,   scl_level_next;
  logic       sda_level,   sda_level_next;
  logic       done, nack, refused, lines_upd;

  // Expander byte k (1..4): nibble, enable on odd k, backlight, select
  function automatic logic [7:0] expander_byte(input logic [7:0] hb, input logic sel,
                                               input logic bl, input logic [2:0] k);
    logic [7:0] v;
    v = (k <= 3'd2) ? (hb & i2cln_pkg::NIBBLE_HI) : ({hb[3:0], 4'h0});
    if (k[0]) v = v | i2cln_pkg::EXP_EN;
    if (bl)   v = v | i2cln_pkg::EXP_BL;
    if (sel)  v = v | i2cln_pkg::EXP_RS;
    return v;
  endfunction

  // Take the next request when the output register is free or being emptied
  assign q_pop = q_valid && (!res_valid || !res_stall);

  // One sequencer step
  always_comb begin
    phase_next       = phase;
    sub_step_next    = sub_step;
    bit_count_next   = bit_count;
    byte_count_next  = byte_count;
    shift_byte_next  = shift_byte;
    held_byte_next   = held_byte;
    held_select_next = held_select;
    error_seen_next  = error_seen;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    done      = 1'b0;
    nack      = 1'b0;
    refused   = 1'b0;
    lines_upd = 1'b0;

    if (q_item.op == i2cln_pkg::OP_SEND) begin
      if (phase != i2cln_pkg::PH_IDLE) begin
        refused = 1'b1;
      end else begin
        held_byte_next   = q_item.lcd_byte;
        held_select_next = q_item.register_select;
        error_seen_next  = 1'b0;
        byte_count_next  = 3'd0;
        bit_count_next   = 3'd7;
        shift_byte_next  = {cfg.slave_address, 1'b0};
        phase_next       = i2cln_pkg::PH_START;
        sub_step_next    = 2'd0;
        lines_upd        = 1'b1;
      end
    end else begin
      lines_upd = 1'b1;
      case (phase)
        i2cln_pkg::PH_IDLE: begin
          sub_step_next = sub_step;
        end
        i2cln_pkg::PH_START: begin
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            phase_next    = i2cln_pkg::PH_BIT;
            sub_step_next = 2'd0;
          end
        end
        i2cln_pkg::PH_BIT: begin
          if (sub_step == 2'd0) begin
            sub_step_next = 2'd1;
          end else if (sub_step == 2'd1) begin
            sub_step_next = 2'd0;
            if (bit_count == 3'd0) begin
              phase_next = i2cln_pkg::PH_ACK;
            end else begin
              bit_count_next = bit_count - 3'd1;
            end
          end else begin
            phase_next    = i2cln_pkg::PH_IDLE;
            sub_step_next = 2'd0;
          end
        end
        i2cln_pkg::PH_ACK: begin
          if (sub_step == 2'd0) begin
            sub_step_next = 2'd1;
          end else if (sub_step == 2'd1) begin
            // end of clock-high half: a high line is a NACK
            if (q_item.sda_sample) error_seen_next = 1'b1;
            sub_step_next = 2'd2;
          end else if (sub_step == 2'd2) begin
            sub_step_next = 2'd0;
            if (error_seen || byte_count >= i2cln_pkg::LAST_DATA_BYTE) begin
              phase_next = i2cln_pkg::PH_STOP;
            end else begin
              byte_count_next = byte_count + 3'd1;
              shift_byte_next = expander_byte(held_byte, held_select,
                                              cfg.backlight_on, byte_count + 3'd1);
              bit_count_next  = 3'd7;
              phase_next      = i2cln_pkg::PH_BIT;
            end
          end else begin
            phase_next    = i2cln_pkg::PH_IDLE;
            sub_step_next = 2'd0;
          end
        end
        i2cln_pkg::PH_STOP: begin
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            phase_next    = i2cln_pkg::PH_IDLE;
            sub_step_next = 2'd0;
            done          = 1'b1;
            nack          = error_seen;
          end
        end
        default: begin
          phase_next    = i2cln_pkg::PH_IDLE;
          sub_step_next = 2'd0;
        end
      endcase
    end

    // Line levels for the phase just entered
    if (lines_upd) begin
      case (phase_next)
        i2cln_pkg::PH_START: begin
          scl_level_next = (sub_step_next < 2'd2);
          sda_level_next = (sub_step_next == 2'd0);
        end
        i2cln_pkg::PH_BIT: begin
          scl_level_next = (sub_step_next == 2'd1);
          sda_level_next = shift_byte_next[bit_count_next];
        end
        i2cln_pkg::PH_ACK: begin
          scl_level_next = (sub_step_next == 2'd1);
          sda_level_next = 1'b1;
        end
        i2cln_pkg::PH_STOP: begin
          scl_level_next = (sub_step_next >= 2'd1);
          sda_level_next = (sub_step_next == 2'd2);
        end
        default: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
        end
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cln_pkg::PH_IDLE;
      sub_step    <= 2'd0;
      bit_count   <= 3'd7;
      byte_count  <= 3'd0;
      shift_byte  <= 8'd0;
      held_byte   <= 8'd0;
      held_select <= 1'b0;
      error_seen  <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
    end else if (q_pop) begin
      phase       <= phase_next;
      sub_step    <= sub_step_next;
      bit_count   <= bit_count_next;
      byte_count  <= byte_count_next;
      shift_byte  <= shift_byte_next;
      held_byte   <= held_byte_next;
      held_select <= held_select_next;
      error_seen  <= error_seen_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_data.scl_release <= scl_level_next;
      res_data.sda_release <= sda_level_next;
      res_data.busy_res    <= (phase_next != i2cln_pkg::PH_IDLE);
      res_data.done_res    <= done;
      res_data.nack_error  <= nack;
      res_data.refused     <= refused;
    end
  end

  `I2CLN_ASSERT(a_no_pop_on_stall, (res_valid && res_stall) |-> !q_pop)
  `I2CLN_ASSERT(a_done_ends_busy, (res_valid && res_data.done_res) |-> !res_data.busy_res)
  `I2CLN_ASSERT(a_nack_with_done, (res_valid && res_data.nack_error) |-> res_data.done_res)
  `I2CLN_ASSERT(a_refused_busy, (res_valid && res_data.refused) |-> res_data.busy_res)

endmodule

[design/i2c_lcd_nibble_writer.sv]
// Top level of the I2C display nibble writer: configuration registers,
// front queue and bus sequencer. Depends on i2cln_pkg, i2cln_queue, i2cln_engine.
//
//   channel   signals                          direction  payload
//   request   req_valid / req_stall / req_data in         i2cln_pkg::req_t
//   result    res_valid / res_stall / res_data out        i2cln_pkg::res_t
//   config    cfg_we / cfg_index / cfg_data    in         7-bit write data
//
// One request per clock cycle sustained while the result side does not stall; each request yields one result.
// A request passes the two-entry queue and the sequencer step: it is registered
// in a queue slot, and then its result is registered in the output register.
// Reset is synchronous: queue empty, bus idle with both lines released.
// A result stall holds the output register; the queue absorbs up to two requests.
`timescale 1ns / 1ps

module i2c_lcd_nibble_writer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  i2cln_pkg::req_t                        req_data,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output i2cln_pkg::res_t                        res_data,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic [i2cln_pkg::CfgDataWidth-1:0]     cfg_data
);

  i2cln_pkg::cfg_t    cfg;
  logic               q_valid;
  logic               q_pop;
  i2cln_pkg::q_item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= i2cln_pkg::SLAVE_ADDRESS_RESET;
      cfg.backlight_on  <= i2cln_pkg::BACKLIGHT_ON_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cln_pkg::CFG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data;
        i2cln_pkg::CFG_BACKLIGHT_ON:  cfg.backlight_on  <= cfg_data[0];
        default: begin
          cfg.backlight_on <= cfg.backlight_on;
        end
      endcase
    end
  end

  i2cln_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  i2cln_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

[tb/nibble_bus_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the I2C display nibble writer: watches the request, result and
// config ports, predicts line levels and flags per request, compares in order.
// Depends on i2cln_pkg.

module nibble_bus_checker
  import i2cln_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_stall,
  input  req_t                    req_data,
  input  logic                    res_valid,
  input  logic                    res_stall,
  input  res_t                    res_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output int                      err_count,
  output int                      pending
);

  // Shadow copy of the registers
  logic [6:0] cur_address;
  logic       cur_backlight;

  // Shadow copy of the bus sequencer
  logic [2:0] phase;
  logic [1:0] sub_step;
  logic [2:0] bit_count;
  logic [2:0] byte_count;
  logic [7:0] shift_byte;
  logic [7:0] held_byte;
  logic       held_select;
  logic       error_seen;
  logic       scl_level;
  logic       sda_level;

  // Line levels and flags still owed by the block, oldest first
  res_t levels_due[$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic log_fault(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) log_fault($sformatf("%s got %b expected %b", name, got, want));
  endtask

  // Expander byte k (1..4): nibble in 7..4, enable, backlight, register select
  function automatic logic [7:0] nibble_frame(input logic [2:0] k);
    logic [7:0] v;
    v = (k <= 3'd2) ? (held_byte & NIBBLE_HI) : {held_byte[3:0], 4'b0000};
    if (k[0]) v = v | EXP_EN;
    if (cur_backlight) v = v | EXP_BL;
    if (held_select) v = v | EXP_RS;
    return v;
  endfunction

  // One request through the sequencer; returns the result it should produce
  task automatic predict_levels(input req_t rq, output res_t o);
    logic fin;
    fin = 1'b0;
    o   = '0;
    if (rq.command == OP_SEND) begin
      if (phase != PH_IDLE) begin
        o.refused = 1'b1;
      end else begin
        held_byte   = rq.lcd_byte;
        held_select = rq.register_select;
        error_seen  = 1'b0;
        byte_count  = 3'd0;
        bit_count   = 3'd7;
        shift_byte  = {cur_address, 1'b0};
        phase       = PH_START;
        sub_step    = 2'd0;
      end
    end else if (phase != PH_IDLE) begin
      case (phase)
        PH_START: begin
          if (sub_step < 2'd2) sub_step = sub_step + 2'd1;
          else begin
            phase    = PH_BIT;
            sub_step = 2'd0;
          end
        end
        PH_BIT: begin
          if (sub_step == 2'd0) sub_step = 2'd1;
          else if (sub_step == 2'd1) begin
            if (bit_count == 3'd0) phase = PH_ACK;
            else bit_count = bit_count - 3'd1;
            sub_step = 2'd0;
          end else begin
            phase    = PH_IDLE;
            sub_step = 2'd0;
          end
        end
        PH_ACK: begin
          if (sub_step == 2'd0) sub_step = 2'd1;
          else if (sub_step == 2'd1) begin
            if (rq.sda_sample) error_seen = 1'b1;
            sub_step = 2'd2;
          end else if (sub_step == 2'd2) begin
            if (error_seen || byte_count >= LAST_DATA_BYTE) begin
              phase = PH_STOP;
            end else begin
              byte_count = byte_count + 3'd1;
              shift_byte = nibble_frame(byte_count);
              bit_count  = 3'd7;
              phase      = PH_BIT;
            end
            sub_step = 2'd0;
          end else begin
            phase    = PH_IDLE;
            sub_step = 2'd0;
          end
        end
        PH_STOP: begin
          if (sub_step < 2'd2) sub_step = sub_step + 2'd1;
          else begin
            phase    = PH_IDLE;
            sub_step = 2'd0;
            fin      = 1'b1;
          end
        end
        default: begin
          phase    = PH_IDLE;
          sub_step = 2'd0;
        end
      endcase
    end

    // A refused send leaves the lines where they were
    if (!o.refused) begin
      case (phase)
        PH_START: begin
          scl_level = (sub_step < 2'd2);
          sda_level = (sub_step == 2'd0);
        end
        PH_BIT: begin
          scl_level = (sub_step == 2'd1);
          sda_level = shift_byte[bit_count];
        end
        PH_ACK: begin
          scl_level = (sub_step == 2'd1);
          sda_level = 1'b1;
        end
        PH_STOP: begin
          scl_level = (sub_step >= 2'd1);
          sda_level = (sub_step == 2'd2);
        end
        default: begin
          scl_level = 1'b1;
          sda_level = 1'b1;
        end
      endcase
    end

    o.scl_release = scl_level;
    o.sda_release = sda_level;
    o.busy_res    = (phase != PH_IDLE);
    o.done_res    = fin;
    o.nack_error  = fin & error_seen;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t fresh;
    if (rst) begin
      cur_address   = SLAVE_ADDRESS_RESET;
      cur_backlight = BACKLIGHT_ON_RESET;
      phase         = PH_IDLE;
      sub_step      = 2'd0;
      bit_count     = 3'd7;
      byte_count    = 3'd0;
      shift_byte    = 8'h00;
      held_byte     = 8'h00;
      held_select   = 1'b0;
      error_seen    = 1'b0;
      scl_level     = 1'b1;
      sda_level     = 1'b1;
      levels_due.delete();
    end else begin
      // Result side: compare against the oldest prediction
      if (res_valid && !res_stall) begin
        if (levels_due.size() == 0) begin
          log_fault($sformatf("result %b with no request outstanding", res_data));
        end else begin
          want = levels_due.pop_front();
          check_field("scl_release", res_data.scl_release, want.scl_release);
          check_field("sda_release", res_data.sda_release, want.sda_release);
          check_field("busy_res",    res_data.busy_res,    want.busy_res);
          check_field("done_res",    res_data.done_res,    want.done_res);
          check_field("nack_error",  res_data.nack_error,  want.nack_error);
          check_field("refused",     res_data.refused,     want.refused);
        end
      end
      // Request side: run the shadow sequencer
      if (req_valid && !req_stall) begin
        predict_levels(req_data, fresh);
        levels_due.push_back(fresh);
      end
      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDRESS: cur_address   = cfg_data[6:0];
          CFG_BACKLIGHT_ON:  cur_backlight = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = levels_due.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the I2C display nibble writer bench: clock, reset, request stimulus,
// result stall pattern and verdict. Depends on i2cln_pkg, nibble_bus_checker and the RTL.

module testbench;
  import i2cln_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    req_valid;
  logic                    req_stall;
  req_t                    req_data;
  logic                    res_valid;
  logic                    res_stall;
  res_t                    res_data;
  logic                    cfg_we;
  logic                    cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;
  int                      err_count;
  int                      pending;

  int burst_left;
  int items_sent;
  int transfers_framed;
  int nacks_forced;
  int busy_sends;
  int stall_mode;
  int stall_left;

  i2c_lcd_nibble_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nibble_bus_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result stall: segments of no stall, light, heavy and periodic stalling
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_mode)
      0:       res_stall <= 1'b0;
      1:       res_stall <= ($urandom_range(0, 3) == 0);
      2:       res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= stall_left[2];
    endcase
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_req(input req_t rq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_tick();
    req_t rq;
    rq.command         = OP_TICK;
    rq.lcd_byte        = 8'($urandom_range(0, 255));
    rq.register_select = 1'($urandom_range(0, 1));
    rq.sda_sample      = 1'($urandom_range(0, 1));
    drive_req(rq);
  endtask

  // Hold requests until every outstanding result is back, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [6:0] addr, input logic bl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_data  <= addr;
    @(negedge clk);
    cfg_index <= CFG_BACKLIGHT_ON;
    cfg_data  <= {6'($urandom_range(0, 63)), bl};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One send followed by ticks up to the stop; the ACK slot of byte nack_at
  // (0 = address byte, 4 = last nibble byte) sees SDA high, > 4 means none.
  // Stray sends are thrown in only while the bus is surely busy.
  task automatic run_transfer(input logic [7:0] byte_val, input logic rs,
                              input int nack_at, input int intrude_pct);
    req_t rq;
    int   last_busy;
    int   t;
    rq.command         = OP_SEND;
    rq.lcd_byte        = byte_val;
    rq.register_select = rs;
    rq.sda_sample      = 1'($urandom_range(0, 1));
    drive_req(rq);
    transfers_framed++;
    if (nack_at <= 4) nacks_forced++;
    // ACK of byte k is sampled on tick 21 + 19k; stop ends four ticks later
    last_busy = (nack_at <= 4) ? 24 + 19 * nack_at : 100;
    for (t = 1; t <= last_busy + 1; t++) begin
      if ($urandom_range(0, 99) < intrude_pct) begin
        rq.command         = OP_SEND;
        rq.lcd_byte        = 8'($urandom_range(0, 255));
        rq.register_select = 1'($urandom_range(0, 1));
        rq.sda_sample      = 1'($urandom_range(0, 1));
        drive_req(rq);
        busy_sends++;
      end
      rq.command         = OP_TICK;
      rq.lcd_byte        = 8'($urandom_range(0, 255));
      rq.register_select = 1'($urandom_range(0, 1));
      if (t >= 21 && (t - 21) % 19 == 0) rq.sda_sample = ((t - 21) / 19 == nack_at);
      else rq.sda_sample = 1'($urandom_range(0, 1));
      drive_req(rq);
    end
  endtask

  // Stimulus
  initial begin
    req_t       rq;
    logic [6:0] addr;
    logic [7:0] byte_val;
    int         guard;
    int         n;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_data   = '0;
    res_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SLAVE_ADDRESS;
    cfg_data   = '0;
    burst_left = 0;
    items_sent = 0;
    transfers_framed = 0;
    nacks_forced     = 0;
    busy_sends       = 0;
    stall_mode = 0;
    stall_left = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ticks on an idle bus, then short transfers aborted at the address byte,
    // one with the reset register values, one with address 127 and backlight off
    idle_tick();
    idle_tick();
    run_transfer(8'hFF, 1'b1, 0, 10);
    drain();
    write_cfg(7'd127, 1'b0);
    run_transfer(8'h00, 1'b0, 0, 10);
    drain();
    write_cfg(7'd0, 1'b1);

    // Random: about half complete transfers, the rest aborted at a random byte
    while (items_sent < 540) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0:       addr = 7'd0;
          1:       addr = 7'd127;
          2:       addr = SLAVE_ADDRESS_RESET;
          default: addr = 7'($urandom_range(0, 127));
        endcase
        write_cfg(addr, 1'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 3))
        0:       byte_val = 8'h00;
        1:       byte_val = 8'hFF;
        default: byte_val = 8'($urandom_range(0, 255));
      endcase
      run_transfer(byte_val, 1'($urandom_range(0, 1)), $urandom_range(0, 9), 3);
      repeat ($urandom_range(0, 3)) idle_tick();
    end

    // Noise: unstructured requests, sends now and then
    for (n = 0; n < 120; n++) begin
      rq.command         = ($urandom_range(0, 9) == 0) ? OP_SEND : OP_TICK;
      rq.lcd_byte        = 8'($urandom_range(0, 255));
      rq.register_select = 1'($urandom_range(0, 1));
      rq.sda_sample      = 1'($urandom_range(0, 1));
      drive_req(rq);
    end
    req_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);

    $display("%0d requests driven: %0d transfers framed, %0d with a forced missing ack,",
             items_sent, transfers_framed, nacks_forced);
    $display("%0d sends aimed at a busy bus, plus idle ticks and unstructured noise",
             busy_sends);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (err_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("watchdog expired with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
